// File: rtl/core/bplm_pkg.sv
// ----------------------------------------------------------------------------
// bplm_pkg
// Shared defaults and the command and status bundles that pass between the
// list manager's controller and its datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bplm_pkg;

  localparam int NODES_DEF = 16;
  localparam int LISTS_DEF = 2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic clear_wr;
    logic unlink;
    logic append;
    logic load_out;
  } bplm_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic quick;
    logic is_put;
    logic clr_last;
  } bplm_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/bplm_ram.sv
// ----------------------------------------------------------------------------
// bplm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bplm_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/core/bplm_ctrl.sv
// ----------------------------------------------------------------------------
// bplm_ctrl
// Controller state machine: sequences the membership clearing pass, item
// acceptance, the link read, unlink and append steps and the result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module bplm_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  output logic                  result_valid,
  input  logic                  result_stall,
  input  bplm_pkg::bplm_stat_t  stat,
  output bplm_pkg::bplm_cmd_t   cmd
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_UNLINK = 3'd3;
  localparam logic [2:0] ST_APPEND = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       result_valid_next;

  assign item_stall = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item_valid) begin
          cmd.accept = 1'b1;
          state_next = stat.quick ? ST_DONE : ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_UNLINK;
      end
      ST_UNLINK: begin
        cmd.unlink = 1'b1;
        state_next = stat.is_put ? ST_APPEND : ST_DONE;
      end
      ST_APPEND: begin
        cmd.append = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        // The result register may still hold the previous item's result.
        if (!result_valid || !result_stall) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      result_valid_next = 1'b1;
    end else if (!result_stall) begin
      result_valid_next = 1'b0;
    end else begin
      result_valid_next = result_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |-> !cmd.load_out)
    else $error("result overwritten while held");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> !cmd.accept)
    else $error("item accepted while another is in progress");
`endif

endmodule

`default_nettype wire

// File: rtl/core/bplm_dp.sv
// ----------------------------------------------------------------------------
// bplm_dp
// Datapath: link and membership RAMs, per-list head, tail and length
// registers, the item and result registers and the unlink and append logic.
// ----------------------------------------------------------------------------
`default_nettype none

module bplm_dp #(
  parameter int NODES = bplm_pkg::NODES_DEF,
  parameter int LISTS = bplm_pkg::LISTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  bplm_pkg::bplm_cmd_t          cmd,
  output bplm_pkg::bplm_stat_t         stat,
  input  logic [1:0]                   mode,
  input  logic [$clog2(NODES)-1:0]     node_index,
  input  logic [$clog2(LISTS)-1:0]     list_select,
  output logic [1:0]                   status,
  output logic [$clog2(NODES)-1:0]     got_node,
  output logic [$clog2(NODES+1)-1:0]   list_length
);

  localparam int NW = $clog2(NODES);
  localparam int LW = $clog2(LISTS);
  localparam int MW = $clog2(LISTS + 1);
  localparam int CW = $clog2(NODES + 1);

  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_GET   = 2'd1;
  localparam logic [1:0] MODE_COUNT = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [LW:0] LISTS_V = (LW + 1)'(LISTS);
  localparam logic [NW:0] NODES_V = (NW + 1)'(NODES);

  // Item and result registers.
  logic [NW-1:0] r_node;
  logic [LW-1:0] r_list;
  logic          r_put;
  logic [1:0]    res_status;
  logic [NW-1:0] res_got;
  logic [CW-1:0] res_len;

  // Per-list registers.
  logic [NW-1:0] head  [LISTS];
  logic [NW-1:0] tail  [LISTS];
  logic [CW-1:0] count [LISTS];

  logic [NW-1:0] clr_addr;

  // RAM ports.
  logic          next_we, prev_we, memb_we;
  logic [NW-1:0] next_waddr, prev_waddr, memb_waddr;
  logic [NW-1:0] next_wdata, prev_wdata;
  logic [MW-1:0] memb_wdata;
  logic [NW-1:0] next_rd, prev_rd;
  logic [MW-1:0] memb_rd;

  // Accept-side decode.
  logic          sel_ok, node_ok, is_put, is_get, is_count, walk;
  logic [LW-1:0] sel_idx;
  logic [NW-1:0] head_sel;
  logic [CW-1:0] cnt_sel;

  // Unlink and append terms.
  logic [MW-1:0] lm1;
  logic [LW-1:0] ul;
  logic          in_list, many, at_head, at_tail;
  logic          unl_next, unl_prev, app_link;

  assign sel_ok   = ({1'b0, list_select} < LISTS_V);
  assign node_ok  = ({1'b0, node_index} < NODES_V);
  assign is_put   = (mode == MODE_PUT);
  assign is_get   = (mode == MODE_GET);
  assign is_count = (mode == MODE_COUNT);
  assign sel_idx  = sel_ok ? list_select : '0;
  assign head_sel = head[sel_idx];
  assign cnt_sel  = count[sel_idx];
  assign walk     = sel_ok && ((is_put && node_ok) || (is_get && (cnt_sel != '0)));

  assign lm1     = memb_rd - MW'(1);
  assign ul      = lm1[LW-1:0];
  assign in_list = (memb_rd != '0);
  assign many    = (count[ul] > CW'(1));
  assign at_head = (head[ul] == r_node);
  assign at_tail = (tail[ul] == r_node);

  // Neighbour links are patched only when the node sits inside a longer list.
  assign unl_next = cmd.unlink && in_list && many && !at_head;
  assign unl_prev = cmd.unlink && in_list && many && !at_tail;
  assign app_link = cmd.append && (count[r_list] != '0);

  always_comb begin
    next_we    = unl_next || app_link;
    next_waddr = cmd.append ? tail[r_list] : prev_rd;
    next_wdata = cmd.append ? r_node : next_rd;

    prev_we    = unl_prev || app_link;
    prev_waddr = cmd.append ? r_node : next_rd;
    prev_wdata = cmd.append ? tail[r_list] : prev_rd;

    memb_we    = cmd.clear_wr || cmd.append || (cmd.unlink && !r_put);
    memb_waddr = cmd.clear_wr ? clr_addr : r_node;
    memb_wdata = cmd.append ? (MW'(r_list) + MW'(1)) : '0;
  end

  assign stat.quick    = !walk;
  assign stat.is_put   = r_put;
  assign stat.clr_last = (clr_addr == NW'(NODES - 1));

  bplm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_next (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (r_node),
    .rdata (next_rd)
  );

  bplm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_prev (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .raddr (r_node),
    .rdata (prev_rd)
  );

  bplm_ram #(.WIDTH(MW), .DEPTH(NODES)) u_memb (
    .clk   (clk),
    .we    (memb_we),
    .waddr (memb_waddr),
    .wdata (memb_wdata),
    .raddr (r_node),
    .rdata (memb_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      for (int i = 0; i < LISTS; i++) begin
        count[i] <= '0;
      end
    end else begin
      if (cmd.clear_wr) begin
        clr_addr <= clr_addr + NW'(1);
      end
      if (cmd.unlink && in_list) begin
        count[ul] <= many ? (count[ul] - CW'(1)) : '0;
      end else if (cmd.append) begin
        count[r_list] <= count[r_list] + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      r_list  <= list_select;
      r_put   <= is_put;
      r_node  <= is_put ? node_index : head_sel;
      res_got <= (is_get && walk) ? head_sel : '0;
      res_len <= (is_count && sel_ok) ? cnt_sel : '0;
      if (!(is_put || is_get || is_count)) begin
        res_status <= ST_OK;
      end else if (!sel_ok || (is_put && !node_ok)) begin
        res_status <= ST_RANGE;
      end else if (is_get && (cnt_sel == '0)) begin
        res_status <= ST_EMPTY;
      end else begin
        res_status <= ST_OK;
      end
    end
    if (cmd.unlink && in_list && many) begin
      if (at_head) begin
        head[ul] <= next_rd;
      end
      if (at_tail) begin
        tail[ul] <= prev_rd;
      end
    end
    if (cmd.append) begin
      if (count[r_list] == '0) begin
        head[r_list] <= r_node;
      end
      tail[r_list] <= r_node;
    end
    if (cmd.load_out) begin
      status      <= res_status;
      got_node    <= res_got;
      list_length <= res_len;
    end
  end

`ifndef SYNTHESIS
  a_unlink_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.unlink && in_list) |-> (count[ul] != '0))
    else $error("node recorded in a list whose length is zero");

  a_append_room: assert property (@(posedge clk) disable iff (rst)
    cmd.append |-> (count[r_list] < CW'(NODES)))
    else $error("append to a list that already holds every node");
`endif

endmodule

`default_nettype wire

// File: rtl/core/buffer_pool_list_manager.sv
// ----------------------------------------------------------------------------
// buffer_pool_list_manager
// Keeps a pool of buffer nodes in FIFO lists built as doubly linked lists,
// with put (move to tail), get (pop head) and count operations.
//
//   Channel   Handshake                   Fields
//   item      item_valid / item_stall     mode, node_index, list_select
//   result    result_valid / result_stall status, got_node, list_length
//
// Count, range errors, an empty get and the unused mode go straight from
// acceptance to the result hand-off; a get adds the registered read of the
// link RAMs and an unlink step, and a put adds a separate append step.
// One item is in progress at a time; the next is taken once the previous
// result is in the output register, even while that result is still stalled.
// After reset a clearing pass over all NODES addresses empties the
// membership RAM; item_stall stays high throughout it.
// ----------------------------------------------------------------------------
`default_nettype none

module buffer_pool_list_manager #(
  parameter int NODES = bplm_pkg::NODES_DEF,
  parameter int LISTS = bplm_pkg::LISTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic [1:0]                  mode,
  input  logic [$clog2(NODES)-1:0]    node_index,
  input  logic [$clog2(LISTS)-1:0]    list_select,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [1:0]                  status,
  output logic [$clog2(NODES)-1:0]    got_node,
  output logic [$clog2(NODES+1)-1:0]  list_length
);

  bplm_pkg::bplm_cmd_t  cmd;
  bplm_pkg::bplm_stat_t stat;

  bplm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  bplm_dp #(.NODES(NODES), .LISTS(LISTS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .mode        (mode),
    .node_index  (node_index),
    .list_select (list_select),
    .status      (status),
    .got_node    (got_node),
    .list_length (list_length)
  );

endmodule

`default_nettype wire
